[src/pbsp_pkg.sv]
// ----------------------------------------------------------------------------
// pbsp_pkg
// Shared constants and lookup functions for the plane / box section block.
// ----------------------------------------------------------------------------
package pbsp_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int NORMAL_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_POINTS   = 6;
  localparam int NUM_EDGES    = 12;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  // first end of each box edge
  function automatic logic [2:0] edge_a(input logic [3:0] e);
    logic [2:0] r;
    case (e)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd4;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd7;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd7;
      4'd11:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // second end of each box edge
  function automatic logic [2:0] edge_b(input logic [3:0] e);
    logic [2:0] r;
    case (e)
      4'd0:    r = 3'd1;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd0;
      4'd4:    r = 3'd4;
      4'd5:    r = 3'd5;
      4'd6:    r = 3'd7;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd0;
      4'd9:    r = 3'd2;
      4'd10:   r = 3'd3;
      4'd11:   r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // triple product terms: n[j/2] * a[term_a] * b[term_b], odd terms negated
  function automatic logic [1:0] term_a(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd0;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] term_b(input logic [2:0] j);
    logic [1:0] r;
    case (j)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd0;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[src/plane_box_section_polygon_top.sv]
// ----------------------------------------------------------------------------
// plane_box_section_polygon_top
// Section polygon of a plane with an axis-aligned box, one vertex per
// output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The user must write the box corners (cfg_we/cfg_index/cfg_data) only
//   while idle; the block does not enforce this. Each input transaction
//   carries one plane (normal and offset). The block emits the crossing
//   points as an ordered loop, one vertex per output transaction, with
//   last_vertex set on the final one. A plane that misses the box gives
//   a single transaction with vertex_valid low.
// Throughput: one plane at a time; in_ready is high only when idle. A
//   plane passes through setup and an edge scan, a bit-serial divider
//   per crossing, a bubble sort by orientation test with its swaps, and
//   then the output of each vertex. A single shared multiplier carries
//   all products, the triple product included.
// Reset: box returns to [0,1]^3, sequencer idle, no output pending.
// Stall: a held output keeps its vertex until out_ready.
// ----------------------------------------------------------------------------
module plane_box_section_polygon_top #(
  parameter int COORD_WIDTH  = pbsp_pkg::COORD_WIDTH,
  parameter int NORMAL_WIDTH = pbsp_pkg::NORMAL_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pbsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [NORMAL_WIDTH-1:0]       normal_x,
  input  logic signed [NORMAL_WIDTH-1:0]       normal_y,
  input  logic signed [NORMAL_WIDTH-1:0]       normal_z,
  input  logic signed [COORD_WIDTH-1:0]        plane_offset,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COORD_WIDTH-1:0]        vertex_x,
  output logic signed [COORD_WIDTH-1:0]        vertex_y,
  output logic signed [COORD_WIDTH-1:0]        vertex_z,
  output logic [2:0]                           vertex_index,
  output logic                                 vertex_valid,
  output logic                                 last_vertex
);

  localparam int CW  = COORD_WIDTH;
  localparam int NW  = NORMAL_WIDTH;
  localparam int FB  = pbsp_pkg::FRAC_BITS;
  localparam int MW  = ((CW > NW) ? CW : NW) + 2;
  localparam int SW  = CW + ((NW > FB) ? NW : FB) + 5;
  localparam int DW  = SW + 2;
  localparam int RW  = NW + 2;
  localparam int AW  = 2 * MW + CW + 1;
  localparam int DCW = $clog2(DW + 1);
  localparam int PW  = 3 * CW;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MUL   = 5'd1;
  localparam logic [4:0] S_MSAVE = 5'd2;
  localparam logic [4:0] S_SVAL  = 5'd3;
  localparam logic [4:0] S_EDGE  = 5'd4;
  localparam logic [4:0] S_DIV   = 5'd5;
  localparam logic [4:0] S_DWR   = 5'd6;
  localparam logic [4:0] S_P0RD  = 5'd7;
  localparam logic [4:0] S_P0LD  = 5'd8;
  localparam logic [4:0] S_CRD   = 5'd9;
  localparam logic [4:0] S_CLD   = 5'd10;
  localparam logic [4:0] S_T0    = 5'd11;
  localparam logic [4:0] S_T1    = 5'd12;
  localparam logic [4:0] S_T2    = 5'd13;
  localparam logic [4:0] S_T3    = 5'd14;
  localparam logic [4:0] S_DEC   = 5'd15;
  localparam logic [4:0] S_SW1   = 5'd16;
  localparam logic [4:0] S_SW2   = 5'd17;
  localparam logic [4:0] S_ORD   = 5'd18;
  localparam logic [4:0] S_OLD   = 5'd19;
  localparam logic [4:0] S_OWAIT = 5'd20;

  logic [4:0] state;

  logic signed [CW-1:0] bmin [3];
  logic signed [CW-1:0] bmax [3];
  logic signed [NW-1:0] nrm  [3];

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] mul_p;

  logic signed [SW-1:0] prod  [6];
  logic signed [SW-1:0] sumd;
  logic signed [SW-1:0] s_val [8];
  logic [7:0]           corner_in;
  logic signed [SW-1:0] s_new;

  logic [2:0] cnt;
  logic [3:0] e;
  logic [2:0] j;
  logic [1:0] ax_m;

  logic [DW-1:0]  dq;
  logic [RW-1:0]  rem;
  logic [RW-1:0]  dd;
  logic [DCW-1:0] dcnt;
  logic           dneg, dzero;
  logic [PW-1:0]  pbase;
  logic [1:0]     pax;
  logic [RW:0]    rem_sh;
  logic           qbit;

  logic [2:0]           ea, eb;
  logic [2:0]           ediff;
  logic [1:0]           eax;
  logic signed [SW-1:0] s_a;
  logic signed [NW-1:0] n_ax;
  logic [SW-1:0]        un;
  logic [NW-1:0]        nmag;
  logic [PW-1:0]        corner_a;

  logic [CW-1:0] qv, qs, coord_new;
  logic [PW-1:0] pt_new;

  logic [PW-1:0] pts [pbsp_pkg::MAX_POINTS];
  logic [PW-1:0] rd_a, rd_b;
  logic [2:0]    ra, rb, wa;
  logic          we;
  logic [PW-1:0] wd;

  logic [PW-1:0]          p0, pt_a, pt_b;
  logic signed [CW:0]     da [3];
  logic signed [CW:0]     db [3];
  logic signed [NW:0]     thi;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   term;
  logic [2:0]             kp, si;
  logic                   swapped, swp_now, pass_end, sort_done;
  logic [2:0]             oi;

  assign in_ready = (state == S_IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bmin[0] <= '0;
      bmin[1] <= '0;
      bmin[2] <= '0;
      bmax[0] <= CW'(1) <<< FB;
      bmax[1] <= CW'(1) <<< FB;
      bmax[2] <= CW'(1) <<< FB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbsp_pkg::REG_MIN_X: bmin[0] <= cfg_data;
        pbsp_pkg::REG_MIN_Y: bmin[1] <= cfg_data;
        pbsp_pkg::REG_MIN_Z: bmin[2] <= cfg_data;
        pbsp_pkg::REG_MAX_X: bmax[0] <= cfg_data;
        pbsp_pkg::REG_MAX_Y: bmax[1] <= cfg_data;
        pbsp_pkg::REG_MAX_Z: bmax[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign ax_m = (j >= 3'd3) ? 2'(j - 3'd3) : 2'(j);

  always_comb begin
    mul_a = MW'(bmin[ax_m]);
    mul_b = MW'(nrm[ax_m]);
    unique case (state)
      S_MUL: begin
        mul_a = (j >= 3'd3) ? MW'(bmax[ax_m]) : MW'(bmin[ax_m]);
        mul_b = MW'(nrm[ax_m]);
      end
      S_T0: begin
        mul_a = MW'(nrm[2'(j >> 1)]);
        mul_b = MW'(da[pbsp_pkg::term_a(j)]);
      end
      S_T1: begin
        mul_a = $signed(MW'({1'b0, mul_p[CW-1:0]}));
        mul_b = MW'(db[pbsp_pkg::term_b(j)]);
      end
      S_T2: begin
        mul_a = MW'(thi);
        mul_b = MW'(db[pbsp_pkg::term_b(j)]);
      end
      default: ;
    endcase
  end

  // plane value at corner j
  assign s_new = ((j[0] ? prod[3] : prod[0]) + (j[1] ? prod[4] : prod[1])
                + (j[2] ? prod[5] : prod[2])) * SW'(2) - sumd;

  // edge setup
  assign ea       = pbsp_pkg::edge_a(e);
  assign eb       = pbsp_pkg::edge_b(e);
  assign ediff    = ea ^ eb;
  assign eax      = ediff[0] ? 2'd0 : (ediff[1] ? 2'd1 : 2'd2);
  assign s_a      = s_val[ea];
  assign n_ax     = nrm[eax];
  assign un       = s_a[SW-1] ? (~s_a + SW'(1)) : s_a;
  assign nmag     = n_ax[NW-1] ? (~n_ax + NW'(1)) : n_ax;
  assign corner_a = {(ea[2] ? bmax[2] : bmin[2]), (ea[1] ? bmax[1] : bmin[1]),
                     (ea[0] ? bmax[0] : bmin[0])};

  // divider step
  assign rem_sh = {rem, dq[DW-1]};
  assign qbit   = (rem_sh >= {1'b0, dd});

  // crossing point
  assign qv        = dzero ? '0 : dq[CW-1:0];
  assign qs        = dneg ? (~qv + CW'(1)) : qv;
  assign coord_new = pbase[pax*CW +: CW] + qs;

  always_comb begin
    pt_new = pbase;
    pt_new[pax*CW +: CW] = coord_new;
  end

  // triple product term
  assign term = (state == S_T3) ? (AW'(mul_p) <<< CW) : AW'(mul_p);

  // sort bookkeeping
  assign swp_now   = swapped | (state == S_SW2);
  assign pass_end  = (si == 3'(cnt - 3'd3));
  assign sort_done = pass_end && (!swp_now || kp == 3'(cnt - 3'd3));

  // point store
  always_comb begin
    ra = 3'd0;
    rb = 3'd0;
    we = 1'b0;
    wa = cnt;
    wd = pt_new;
    unique case (state)
      S_CRD: begin
        ra = 3'(si + 3'd1);
        rb = 3'(si + 3'd2);
      end
      S_DWR: we = 1'b1;
      S_SW1: begin
        we = 1'b1;
        wa = 3'(si + 3'd1);
        wd = pt_b;
      end
      S_SW2: begin
        we = 1'b1;
        wa = 3'(si + 3'd2);
        wd = pt_a;
      end
      S_ORD: ra = oi;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pts[wa] <= wd;
    end
    rd_a <= pts[ra];
    rd_b <= pts[rb];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            nrm[0] <= normal_x;
            nrm[1] <= normal_y;
            nrm[2] <= normal_z;
            sumd   <= SW'(plane_offset) <<< FB;
            j      <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: state <= S_MSAVE;
        S_MSAVE: begin
          prod[j] <= SW'(mul_p);
          sumd    <= sumd + SW'(mul_p);
          if (j == 3'd5) begin
            j     <= '0;
            state <= S_SVAL;
          end else begin
            j     <= j + 3'd1;
            state <= S_MUL;
          end
        end
        S_SVAL: begin
          s_val[j]     <= s_new;
          corner_in[j] <= ~s_new[SW-1];
          j            <= j + 3'd1;
          if (j == 3'd7) begin
            e     <= '0;
            cnt   <= '0;
            state <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (e == 4'(pbsp_pkg::NUM_EDGES)) begin
            if (cnt == 3'd0) begin
              vertex_x     <= '0;
              vertex_y     <= '0;
              vertex_z     <= '0;
              vertex_index <= '0;
              vertex_valid <= 1'b0;
              last_vertex  <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_OWAIT;
            end else if (cnt > 3'd2) begin
              kp      <= '0;
              si      <= '0;
              swapped <= 1'b0;
              state   <= S_P0RD;
            end else begin
              oi    <= '0;
              state <= S_ORD;
            end
          end else if (corner_in[ea] != corner_in[eb] &&
                       cnt != 3'(pbsp_pkg::MAX_POINTS)) begin
            dq    <= (DW'(un) << 1) + (DW'(nmag) << 1);
            dd    <= RW'(nmag) << 2;
            rem   <= '0;
            dcnt  <= '0;
            dneg  <= ((s_a != '0) && !s_a[SW-1]) != n_ax[NW-1];
            dzero <= (nmag == '0);
            pbase <= corner_a;
            pax   <= eax;
            state <= S_DIV;
          end else begin
            e <= e + 4'd1;
          end
        end
        S_DIV: begin
          rem  <= qbit ? RW'(rem_sh - {1'b0, dd}) : RW'(rem_sh);
          dq   <= {dq[DW-2:0], qbit};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(DW - 1)) begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          cnt   <= cnt + 3'd1;
          e     <= e + 4'd1;
          state <= S_EDGE;
        end
        S_P0RD: state <= S_P0LD;
        S_P0LD: begin
          p0    <= rd_a;
          state <= S_CRD;
        end
        S_CRD: state <= S_CLD;
        S_CLD: begin
          pt_a  <= rd_a;
          pt_b  <= rd_b;
          da[0] <= (CW+1)'(signed'(rd_a[CW-1:0])) - (CW+1)'(signed'(p0[CW-1:0]));
          da[1] <= (CW+1)'(signed'(rd_a[2*CW-1:CW])) - (CW+1)'(signed'(p0[2*CW-1:CW]));
          da[2] <= (CW+1)'(signed'(rd_a[PW-1:2*CW])) - (CW+1)'(signed'(p0[PW-1:2*CW]));
          db[0] <= (CW+1)'(signed'(rd_b[CW-1:0])) - (CW+1)'(signed'(p0[CW-1:0]));
          db[1] <= (CW+1)'(signed'(rd_b[2*CW-1:CW])) - (CW+1)'(signed'(p0[2*CW-1:CW]));
          db[2] <= (CW+1)'(signed'(rd_b[PW-1:2*CW])) - (CW+1)'(signed'(p0[PW-1:2*CW]));
          acc   <= '0;
          j     <= '0;
          state <= S_T0;
        end
        S_T0: state <= S_T1;
        S_T1: begin
          thi   <= mul_p[CW+NW:CW];
          state <= S_T2;
        end
        S_T2: begin
          acc   <= j[0] ? (acc - term) : (acc + term);
          state <= S_T3;
        end
        S_T3: begin
          acc <= j[0] ? (acc - term) : (acc + term);
          if (j == 3'd5) begin
            state <= S_DEC;
          end else begin
            j     <= j + 3'd1;
            state <= S_T0;
          end
        end
        S_DEC, S_SW2: begin
          if (state == S_DEC && acc[AW-1]) begin
            state <= S_SW1;
          end else if (sort_done) begin
            oi    <= '0;
            state <= S_ORD;
          end else if (pass_end) begin
            kp      <= kp + 3'd1;
            si      <= '0;
            swapped <= 1'b0;
            state   <= S_CRD;
          end else begin
            si      <= si + 3'd1;
            swapped <= swp_now;
            state   <= S_CRD;
          end
        end
        S_SW1: state <= S_SW2;
        S_ORD: state <= S_OLD;
        S_OLD: begin
          vertex_x     <= rd_a[CW-1:0];
          vertex_y     <= rd_a[2*CW-1:CW];
          vertex_z     <= rd_a[PW-1:2*CW];
          vertex_index <= oi;
          vertex_valid <= 1'b1;
          last_vertex  <= (oi == 3'(cnt - 3'd1));
          out_valid    <= 1'b1;
          state        <= S_OWAIT;
        end
        S_OWAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_vertex) begin
              state <= S_IDLE;
            end else begin
              oi    <= oi + 3'd1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/pbsp_chk.sv]
// ----------------------------------------------------------------------------
// pbsp_chk
// Port-level checks for the plane / box section block.
// ----------------------------------------------------------------------------
module pbsp_chk #(
  parameter int COORD_WIDTH  = pbsp_pkg::COORD_WIDTH,
  parameter int NORMAL_WIDTH = pbsp_pkg::NORMAL_WIDTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] vertex_x,
  input logic [2:0]             vertex_index,
  input logic                   vertex_valid,
  input logic                   last_vertex
);

  // idle and output pending never overlap
  a_ready_vs_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output pending");

  // plane taken: busy next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after input transaction");

  // a miss is a single terminal result
  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !vertex_valid) |-> (last_vertex && vertex_index == 3'd0))
    else $error("miss result malformed");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(vertex_x) && $stable(vertex_index)))
    else $error("output changed under stall");

endmodule

bind plane_box_section_polygon_top pbsp_chk #(
  .COORD_WIDTH(COORD_WIDTH),
  .NORMAL_WIDTH(NORMAL_WIDTH)
) u_pbsp_chk (.*);

[tb/plane_box_section_polygon_top_test.sv]
// ----------------------------------------------------------------------------
// plane_box_section_polygon_top_test
// Drives planes against a series of box settings and checks every vertex
// transaction against an in-bench section polygon predictor, under several
// mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module plane_box_section_polygon_top_test;

  typedef struct {
    logic signed [pbsp_pkg::NORMAL_WIDTH-1:0] nx, ny, nz;
    logic signed [pbsp_pkg::COORD_WIDTH-1:0]  offset;
  } plane_t;

  typedef struct {
    logic signed [pbsp_pkg::COORD_WIDTH-1:0] x, y, z;
    logic [2:0]                              index;
    logic                                    valid;
    logic                                    last;
  } vertex_t;

  logic clk, rst;
  logic cfg_we;
  logic [pbsp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pbsp_pkg::COORD_WIDTH-1:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [pbsp_pkg::NORMAL_WIDTH-1:0] normal_x, normal_y, normal_z;
  logic signed [pbsp_pkg::COORD_WIDTH-1:0] plane_offset;
  logic out_valid, out_ready;
  logic signed [pbsp_pkg::COORD_WIDTH-1:0] vertex_x, vertex_y, vertex_z;
  logic [2:0] vertex_index;
  logic vertex_valid, last_vertex;

  plane_box_section_polygon_top dut (.*);

  plane_t  plane_q[$];
  vertex_t vertex_q[$];
  logic signed [pbsp_pkg::COORD_WIDTH-1:0] box[6];
  int send_idle_pct, recv_stall_pct;
  int fail_cnt = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint round_div(longint num, longint den);
    longint unsigned un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    if (ud == 0) return 0;
    q = (2 * un + ud) / (2 * ud);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit turns_back(longint n[3], longint a[3], longint b[3]);
    logic signed [127:0] t, p, q;
    int ia[6] = '{1, 2, 2, 0, 0, 1};
    int ib[6] = '{2, 1, 0, 2, 1, 0};
    t = 0;
    for (int j = 0; j < 6; j++) begin
      p = n[j / 2] * a[ia[j]];
      q = b[ib[j]];
      if (j % 2) t = t - p * q;
      else t = t + p * q;
    end
    return t < 0;
  endfunction

  task automatic add_plane(plane_t pl);
    plane_q.insert(plane_q.size(), pl);
  endtask

  task automatic predict_section(plane_t pl);
    longint lo[3], hi[3], n[3], c[8][3], s[8], pt[6][3], tmp[3], da[3], db[3];
    longint sum_dot, d;
    bit in_box[8], swapped;
    int cnt, a, b, ax;
    int ea[12] = '{0, 1, 3, 2, 6, 4, 5, 7, 4, 6, 7, 5};
    int eb[12] = '{1, 3, 2, 0, 4, 5, 7, 6, 0, 2, 3, 1};
    vertex_t v;
    sum_dot = 0;
    cnt = 0;
    n[0] = pl.nx; n[1] = pl.ny; n[2] = pl.nz;
    for (int i = 0; i < 3; i++) begin
      lo[i] = box[i];
      hi[i] = box[i + 3];
      sum_dot += (lo[i] + hi[i]) * n[i];
    end
    for (int i = 0; i < 8; i++) begin
      d = 0;
      for (int k = 0; k < 3; k++) begin
        c[i][k] = ((i >> k) & 1) ? hi[k] : lo[k];
        d += c[i][k] * n[k];
      end
      s[i] = 2 * d - sum_dot - longint'(pl.offset) * 65536;
      in_box[i] = s[i] >= 0;
    end
    for (int i = 0; i < 12 && cnt < pbsp_pkg::MAX_POINTS; i++) begin
      a = ea[i];
      b = eb[i];
      if (in_box[a] != in_box[b]) begin
        ax = ((a ^ b) & 1) ? 0 : (((a ^ b) & 2) ? 1 : 2);
        for (int k = 0; k < 3; k++) pt[cnt][k] = c[a][k];
        pt[cnt][ax] = c[a][ax] + round_div(-s[a], 2 * n[ax]);
        cnt++;
      end
    end
    if (cnt == 0) begin
      v = '{0, 0, 0, 0, 1'b0, 1'b1};
      vertex_q.insert(vertex_q.size(), v);
      return;
    end
    if (cnt > 2) begin
      for (int p = 0; p < cnt - 2; p++) begin
        swapped = 0;
        for (int i = 0; i < cnt - 2; i++) begin
          for (int k = 0; k < 3; k++) begin
            da[k] = pt[i + 1][k] - pt[0][k];
            db[k] = pt[i + 2][k] - pt[0][k];
          end
          if (turns_back(n, da, db)) begin
            tmp = pt[i + 1];
            pt[i + 1] = pt[i + 2];
            pt[i + 2] = tmp;
            swapped = 1;
          end
        end
        if (!swapped) break;
      end
    end
    for (int i = 0; i < cnt; i++) begin
      v.x = pbsp_pkg::COORD_WIDTH'(pt[i][0]);
      v.y = pbsp_pkg::COORD_WIDTH'(pt[i][1]);
      v.z = pbsp_pkg::COORD_WIDTH'(pt[i][2]);
      v.index = 3'(i);
      v.valid = 1'b1;
      v.last = (i == cnt - 1);
      vertex_q.insert(vertex_q.size(), v);
    end
  endtask

  // plane feed
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= '0;
      plane_offset <= '0;
    end else begin
      if (in_valid && in_ready)
        predict_section('{normal_x, normal_y, normal_z, plane_offset});
      if (!in_valid || in_ready) begin
        if (plane_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          normal_x <= plane_q[0].nx;
          normal_y <= plane_q[0].ny;
          normal_z <= plane_q[0].nz;
          plane_offset <= plane_q[0].offset;
          void'(plane_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // vertex check
  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transaction");
          fail_cnt++;
        end else begin
          e = vertex_q.pop_front();
          if (vertex_x !== e.x) begin
            $error("vertex_x exp %0d got %0d", e.x, vertex_x); fail_cnt++;
          end
          if (vertex_y !== e.y) begin
            $error("vertex_y exp %0d got %0d", e.y, vertex_y); fail_cnt++;
          end
          if (vertex_z !== e.z) begin
            $error("vertex_z exp %0d got %0d", e.z, vertex_z); fail_cnt++;
          end
          if (vertex_index !== e.index) begin
            $error("vertex_index exp %0d got %0d", e.index, vertex_index); fail_cnt++;
          end
          if (vertex_valid !== e.valid) begin
            $error("vertex_valid exp %0d got %0d", e.valid, vertex_valid); fail_cnt++;
          end
          if (last_vertex !== e.last) begin
            $error("last_vertex exp %0d got %0d", e.last, last_vertex); fail_cnt++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [pbsp_pkg::CFG_IDX_W-1:0] idx,
                           logic signed [pbsp_pkg::COORD_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    box[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_box(int x0, int y0, int z0, int x1, int y1, int z1);
    write_reg(pbsp_pkg::REG_MIN_X, x0);
    write_reg(pbsp_pkg::REG_MIN_Y, y0);
    write_reg(pbsp_pkg::REG_MIN_Z, z0);
    write_reg(pbsp_pkg::REG_MAX_X, x1);
    write_reg(pbsp_pkg::REG_MAX_Y, y1);
    write_reg(pbsp_pkg::REG_MAX_Z, z1);
  endtask

  function automatic logic signed [pbsp_pkg::NORMAL_WIDTH-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(46340))) - 16'sd23170;
    endcase
  endfunction

  task automatic add_random_planes(int cnt);
    plane_t pl;
    longint span, off;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(99) < 15) begin
        pl = '{16'($urandom), 16'($urandom), 16'($urandom), $urandom};
      end else begin
        pl.nx = rand_comp();
        pl.ny = rand_comp();
        pl.nz = rand_comp();
        span = 0;
        for (int k = 0; k < 3; k++) begin
          off = longint'(box[k + 3]) - longint'(box[k]);
          if (off < 0) off = -off;
          span += off * ((k == 0) ? (pl.nx < 0 ? -pl.nx : pl.nx) :
                         (k == 1) ? (pl.ny < 0 ? -pl.ny : pl.ny) :
                                    (pl.nz < 0 ? -pl.nz : pl.nz));
        end
        span = (span >>> 16) + 1;
        off = longint'({$urandom, $urandom} % (5 * span / 2 + 1)) - 5 * span / 4;
        if (off > 64'sh7fffffff) off = 64'sh7fffffff;
        if (off < -64'sh80000000) off = -64'sh80000000;
        pl.offset = 32'(off);
      end
      add_plane(pl);
    end
  endtask

  task automatic drain();
    while (plane_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    box = '{0, 0, 0, 65536, 65536, 65536};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset box, directed planes
    add_plane('{16'sh7fff, 0, 0, 0});
    add_plane('{16'sh8000, 0, 0, 0});
    add_plane('{0, 16'sh7fff, 0, 32'sh4000});
    add_plane('{0, 0, 16'sh8000, -32'sh4000});
    add_plane('{18919, 18919, 18919, 0});
    add_plane('{-18919, 18919, -18919, 0});
    add_plane('{18919, 18919, 18919, 32'sh6000});
    add_plane('{23170, 23170, 0, 0});
    add_plane('{23170, 0, -23170, 32'sh2000});
    add_plane('{0, 0, 0, 0});
    add_plane('{0, 0, 0, 32'sh7fffffff});
    add_plane('{16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh7fffffff});
    add_plane('{16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000});
    add_plane('{16'sh7fff, 0, 0, 32'sh10000});
    add_plane('{16'sh7fff, 0, 0, -32'sh8000});
    add_plane('{18919, 18919, 18919, 32'sh1bb67});
    add_plane('{-1, 16'sh7fff, 1, 32'sh100});
    add_plane('{16'sh8000, 16'sh7fff, 16'sh8000, -1});
    add_random_planes(72);
    drain();

    set_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_idle_pct = 68;
    add_random_planes(70);
    drain();

    set_box(32'sh30000, -32'sh12345, 32'sh7ffff, -32'sh20000, 32'sh5000, -32'sh1);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    add_random_planes(70);
    drain();

    set_box(-32'sh8000, 32'sh0, 32'sh20000, 32'sh18000, 32'sh40000, 32'sh20000);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    add_random_planes(70);
    drain();

    set_box(-$urandom_range(32'h7fffff), -$urandom_range(32'h7fffff),
            -$urandom_range(32'h7fffff), $urandom_range(32'h7fffff),
            $urandom_range(32'h7fffff), $urandom_range(32'h7fffff));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_planes(70);
    drain();

    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
